[rtl/bpic_pkg.sv]
// Package with the item types, code constants and controller interface of the integer codec.
`timescale 1ns / 1ps
`default_nettype none
package bpic_pkg;

  localparam logic        MODE_ENCODE = 1'b0;
  localparam logic        MODE_DECODE = 1'b1;

  localparam logic [7:0]  NEG_MARK    = 8'd255;
  localparam logic [7:0]  PFX_ONE_A   = 8'd249;
  localparam logic [7:0]  PFX_ONE_B   = 8'd250;
  localparam logic [7:0]  PFX_MULTI   = 8'd252;
  localparam logic [7:0]  PFX_SHIFT   = 8'd250;  // prefix minus this is the digit count

  localparam logic [31:0] ONE_LIMIT   = 32'd215;
  localparam logic [31:0] TWO_GROUP   = 32'd430;
  localparam logic [31:0] THREE_GROUP = 32'd645;
  localparam logic [31:0] TWO_LIMIT   = 32'd860;
  localparam logic [31:0] CODE_CEIL   = 32'd2136750625;

  // floor(x / 215) == (x * RECIP_215) >> RECIP_SHIFT for every x below 2^31.
  localparam logic [31:0] RECIP_215   = 32'd2557003786;
  localparam int          RECIP_SHIFT = 39;
  localparam logic [7:0]  RADIX_LOW   = 8'd215;

  localparam logic [1:0]  ST_OK       = 2'd0;
  localparam logic [1:0]  ST_OVERFLOW = 2'd1;
  localparam logic [1:0]  ST_BAD_BYTE = 2'd2;

  localparam logic [5:0]  OFFSET_RESET = 6'd1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value_in;
    logic [7:0]         code_in0;
    logic [7:0]         code_in1;
    logic [7:0]         code_in2;
    logic [7:0]         code_in3;
    logic [7:0]         code_in4;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         code_out0;
    logic [7:0]         code_out1;
    logic [7:0]         code_out2;
    logic [7:0]         code_out3;
    logic [7:0]         code_out4;
    logic [2:0]         code_length;
    logic signed [31:0] value_out;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic enc_mul;
    logic enc_dig;
    logic dec_step;
  } dp_cmd_t;

  typedef struct packed {
    logic need_enc;
    logic need_dec;
    logic enc_last;
    logic dec_last;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/bpic_ctrl.sv]
// Controller state machine that sequences the codec datapath.
`timescale 1ns / 1ps
`default_nettype none
module bpic_ctrl
  import bpic_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_ENC_MUL = 5'b00010,
    S_ENC_DIG = 5'b00100,
    S_DEC     = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (sts.need_enc) begin
            state_next = S_ENC_MUL;
          end else if (sts.need_dec) begin
            state_next = S_DEC;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ENC_MUL: state_next = S_ENC_DIG;
      S_ENC_DIG: begin
        state_next = sts.enc_last ? S_DONE : S_ENC_MUL;
      end
      S_DEC: begin
        state_next = sts.dec_last ? S_DONE : S_DEC;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.load     = (state == S_IDLE) && start;
    cmd.enc_mul  = (state == S_ENC_MUL);
    cmd.enc_dig  = (state == S_ENC_DIG);
    cmd.dec_step = (state == S_DEC);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

[rtl/bpic_dp.sv]
// Codec datapath: item classification, base-215 digit peeling and decode accumulation.
`timescale 1ns / 1ps
`default_nettype none
module bpic_dp
  import bpic_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic [5:0] cfg_data,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  cmd,
  output dp_sts_t       sts,
  output out_item_t     out_item
);

  logic [5:0]  offset;
  logic [30:0] rest;
  logic [23:0] quot;
  logic [1:0]  ndig;
  logic [2:0]  idx;
  logic [7:0]  dig [0:3];
  logic [7:0]  obyte [0:4];
  logic [2:0]  olen;
  logic [31:0] oval;
  logic [1:0]  ost;

  logic [31:0] raw;
  logic [7:0]  pfx;
  logic        enc_neg;
  logic        enc_one;
  logic        enc_two;
  logic        enc_ovf;
  logic [62:0] prod;
  logic [7:0]  rem_digit;
  logic [31:0] grp_base;
  logic [7:0]  dec_byte;

  function automatic logic [7:0] shift_digit(input logic [7:0] d, input logic [5:0] off);
    shift_digit = d + {2'b00, off};
  endfunction

  function automatic logic [31:0] unshift(input logic [7:0] b, input logic [5:0] off);
    unshift = {24'd0, b} - {26'd0, off};
  endfunction

  assign raw     = in_item.value_in;
  assign pfx     = in_item.code_in0;
  assign enc_neg = raw[31];
  assign enc_one = !enc_neg && (raw < ONE_LIMIT);
  assign enc_two = !enc_neg && !enc_one && (raw < TWO_LIMIT);
  assign enc_ovf = !enc_neg && (raw >= CODE_CEIL);

  always_comb begin
    sts.need_enc = (in_item.mode == MODE_ENCODE) && !enc_neg && !enc_one && !enc_two
                   && !enc_ovf;
    sts.need_dec = (in_item.mode == MODE_DECODE) && (pfx >= PFX_MULTI) && (pfx != NEG_MARK);
    sts.enc_last = (quot == 24'd0) || (ndig == 2'd3);
    sts.dec_last = (idx == 3'd1);
  end

  assign prod = {32'd0, rest} * {31'd0, RECIP_215};
  // The remainder is below 215, so the low byte of the difference is exact.
  assign rem_digit = rest[7:0] - (quot[7:0] * RADIX_LOW);
  assign dec_byte = dig[2'(idx - 3'd1)];

  always_comb begin
    if (raw >= THREE_GROUP) begin
      grp_base = THREE_GROUP;
    end else if (raw >= TWO_GROUP) begin
      grp_base = TWO_GROUP;
    end else begin
      grp_base = ONE_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 5; k++) begin
        obyte[k] <= 8'd0;
      end
      olen <= 3'd0;
      oval <= 32'd0;
      ost  <= ST_OK;
      rest <= raw[30:0];
      ndig <= 2'd0;
      dig[0] <= in_item.code_in1;
      dig[1] <= in_item.code_in2;
      dig[2] <= in_item.code_in3;
      dig[3] <= in_item.code_in4;
      idx  <= 3'(pfx - PFX_SHIFT);
      if (in_item.mode == MODE_ENCODE) begin
        if (enc_neg) begin
          obyte[0] <= NEG_MARK;
          olen     <= 3'd1;
        end else if (enc_one) begin
          obyte[0] <= shift_digit(raw[7:0], offset);
          olen     <= 3'd1;
        end else if (enc_two) begin
          obyte[0] <= (grp_base == THREE_GROUP) ? PFX_ONE_A + 8'd2 :
                      (grp_base == TWO_GROUP)   ? PFX_ONE_B : PFX_ONE_A;
          obyte[1] <= shift_digit(8'(raw - grp_base), offset);
          olen     <= 3'd2;
        end else if (enc_ovf) begin
          ost <= ST_OVERFLOW;
        end
      end else begin
        if (pfx == NEG_MARK) begin
          oval <= 32'hFFFF_FFFF;
          olen <= 3'd1;
        end else if (pfx >= PFX_MULTI) begin
          // Digit count plus the prefix byte.
          olen <= 3'(pfx - PFX_SHIFT) + 3'd1;
        end else if (pfx >= PFX_ONE_A) begin
          oval <= unshift(in_item.code_in1, offset) +
                  ((pfx == PFX_ONE_A) ? ONE_LIMIT :
                   (pfx == PFX_ONE_B) ? TWO_GROUP : THREE_GROUP);
          olen <= 3'd2;
        end else if (pfx < {2'b00, offset}) begin
          oval <= 32'hFFFF_FFFE;
          ost  <= ST_BAD_BYTE;
        end else begin
          oval <= unshift(pfx, offset);
          olen <= 3'd1;
        end
      end
    end
    if (cmd.enc_mul) begin
      quot <= prod[62:RECIP_SHIFT];
    end
    if (cmd.enc_dig) begin
      obyte[3'(ndig) + 3'd1] <= shift_digit(rem_digit, offset);
      rest <= {7'd0, quot};
      ndig <= ndig + 2'd1;
      if (sts.enc_last) begin
        obyte[0] <= PFX_MULTI + 8'(ndig) - 8'd1;
        olen     <= 3'(ndig) + 3'd2;
      end
    end
    if (cmd.dec_step) begin
      oval <= (oval * ONE_LIMIT) + unshift(dec_byte, offset);
      idx  <= idx - 3'd1;
    end
  end

  always_comb begin
    out_item.code_out0   = obyte[0];
    out_item.code_out1   = obyte[1];
    out_item.code_out2   = obyte[2];
    out_item.code_out3   = obyte[3];
    out_item.code_out4   = obyte[4];
    out_item.code_length = olen;
    out_item.value_out   = oval;
    out_item.status      = ost;
  end

endmodule
`default_nettype wire

[rtl/base215_prefix_int_codec.sv]
// Top level of the base-215 prefix-length integer codec.
// Single-step codes go from the accepting edge straight to the done strobe; multi-digit
// codes first pass through the digit states: encode runs a reciprocal-multiply state and
// then a remainder state for each digit, decode one accumulation state for each digit.
// A new item can be accepted from the cycle after done; a busy codec takes no new item.
// Synchronous reset returns the controller to idle and the digit offset to 1; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module base215_prefix_int_codec
  import bpic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire in_item_t   in_item,
  output logic            busy,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_data,
  output logic            done,
  output out_item_t       out_item
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpic_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bpic_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but codec did not go busy");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_item.code_length <= 3'd5))
    else $error("code length out of range");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    (done && (out_item.status != ST_OK)) |-> (out_item.code_length == 3'd0))
    else $error("error item reports a nonzero length");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for the base-215 prefix integer codec: directed and random items checked by a predictor.
`timescale 1ns / 1ps
module tb;
  import bpic_pkg::*;

  localparam logic [31:0] DIGIT_BASE = 32'd215;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  in_item_t   in_item = '0;
  logic       busy;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_data = 6'd0;
  logic       done;
  out_item_t  out_item;

  in_item_t    queued_requests[$];
  out_item_t   predicted_outputs[$];
  logic [5:0]  digit_ofs = OFFSET_RESET;
  int unsigned idle_pct = 0;
  int unsigned fail_count = 0;
  bit          item_taken = 1'b0;

  logic [5:0]  phase_ofs [0:5] = '{6'd1, 6'd0, 6'd34, 6'd29, 6'd17, 6'd0};
  int unsigned phase_idle [0:5] = '{7, 7, 88, 88, 0, 0};
  int unsigned phase_items [0:5] = '{280, 280, 300, 300, 300, 290};

  base215_prefix_int_codec i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] shift_digit(input logic [31:0] d, input logic [5:0] ofs);
    return d[7:0] + {2'b00, ofs};
  endfunction

  function automatic logic [31:0] unshift_byte(input logic [7:0] b, input logic [5:0] ofs);
    return {24'd0, b} - {26'd0, ofs};
  endfunction

  function automatic out_item_t codec_predict(input in_item_t it, input logic [5:0] ofs);
    out_item_t   r;
    logic [7:0]  cb [0:4];
    logic [7:0]  cin [0:4];
    logic [7:0]  p;
    logic [31:0] raw, rest, grp, acc;
    logic [2:0]  len;
    logic [1:0]  st;
    int unsigned n;
    cb = '{default: 8'd0};
    cin[0] = it.code_in0;
    cin[1] = it.code_in1;
    cin[2] = it.code_in2;
    cin[3] = it.code_in3;
    cin[4] = it.code_in4;
    raw = it.value_in;
    p = it.code_in0;
    acc = 32'd0;
    len = 3'd0;
    st = ST_OK;
    n = 0;
    if (it.mode == MODE_ENCODE) begin
      if (raw[31]) begin
        cb[0] = NEG_MARK;
        len = 3'd1;
      end else if (raw < ONE_LIMIT) begin
        cb[0] = shift_digit(raw, ofs);
        len = 3'd1;
      end else if (raw < TWO_LIMIT) begin
        grp = raw / DIGIT_BASE;
        cb[0] = PFX_ONE_A + grp[7:0] - 8'd1;
        cb[1] = shift_digit(raw - grp * DIGIT_BASE, ofs);
        len = 3'd2;
      end else if (raw >= CODE_CEIL) begin
        st = ST_OVERFLOW;
      end else begin
        // Digits go out least significant first; the prefix carries the digit count.
        rest = raw;
        while (rest != 0 && n < 4) begin
          cb[1 + n] = shift_digit(rest % DIGIT_BASE, ofs);
          rest = rest / DIGIT_BASE;
          n++;
        end
        cb[0] = PFX_MULTI + 8'(n) - 8'd2;
        len = 3'(n + 1);
      end
    end else begin
      if (p == NEG_MARK) begin
        acc = 32'hFFFF_FFFF;
        len = 3'd1;
      end else if (p >= PFX_ONE_A && p < PFX_MULTI) begin
        grp = {24'd0, p} - {24'd0, PFX_ONE_A} + 32'd1;
        acc = unshift_byte(cin[1], ofs) + grp * DIGIT_BASE;
        len = 3'd2;
      end else if (p >= PFX_MULTI) begin
        // A digit below the offset is taken as negative; the sum wraps to 32 bits.
        n = 32'(p - PFX_MULTI) + 2;
        for (int i = n; i > 0; i--) begin
          acc = acc * DIGIT_BASE + unshift_byte(cin[i], ofs);
        end
        len = 3'(n + 1);
      end else if (p < {2'b00, ofs}) begin
        acc = 32'hFFFF_FFFE;
        st = ST_BAD_BYTE;
      end else begin
        acc = unshift_byte(p, ofs);
        len = 3'd1;
      end
    end
    r.code_out0 = cb[0];
    r.code_out1 = cb[1];
    r.code_out2 = cb[2];
    r.code_out3 = cb[3];
    r.code_out4 = cb[4];
    r.code_length = len;
    r.value_out = acc;
    r.status = st;
    return r;
  endfunction

  function automatic in_item_t make_item(input logic mode, input logic [31:0] v,
      input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
      input logic [7:0] b3, input logic [7:0] b4);
    in_item_t it;
    it.mode = mode;
    it.value_in = v;
    it.code_in0 = b0;
    it.code_in1 = b1;
    it.code_in2 = b2;
    it.code_in3 = b3;
    it.code_in4 = b4;
    return it;
  endfunction

  // Most items are well-formed codes or values aimed at each code class and its range limits; the rest is noise.
  function automatic in_item_t random_item(input logic [5:0] ofs);
    logic [7:0]  cin [0:4];
    logic [31:0] v, d, scale;
    int unsigned kind, n, i;
    logic        mode;
    mode = 1'($urandom);
    v = $urandom;
    for (i = 0; i < 5; i++) begin
      cin[i] = 8'($urandom);
    end
    kind = $urandom_range(9);
    if (mode == MODE_ENCODE) begin
      case (kind)
        0: v = {1'b1, 31'($urandom)};
        1: v = $urandom_range(214);
        2: v = $urandom_range(859, 215);
        3: begin
          case ($urandom_range(11))
            0: v = 32'd0;
            1: v = 32'd214;
            2: v = 32'd215;
            3: v = 32'd859;
            4: v = 32'd860;
            5: v = 32'd46224;
            6: v = 32'd46225;
            7: v = 32'd9938374;
            8: v = 32'd9938375;
            9: v = CODE_CEIL - 32'd1;
            10: v = CODE_CEIL;
            default: v = 32'h7FFF_FFFF;
          endcase
        end
        4, 5, 6: begin
          n = $urandom_range(4, 2);
          v = 32'd0;
          scale = 32'd1;
          for (i = 0; i < n; i++) begin
            d = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(214));
            if (i == n - 1 && d == 0) begin
              d = 32'd1;
            end
            v = v + d * scale;
            scale = scale * DIGIT_BASE;
          end
        end
        7: v = CODE_CEIL - 32'd1000 + 32'($urandom_range(2000));
        default: ;
      endcase
    end else begin
      case (kind)
        0: cin[0] = NEG_MARK;
        1: begin
          cin[0] = 8'($urandom_range(251, 249));
          if ($urandom_range(4) != 0) begin
            cin[1] = shift_digit($urandom_range(214), ofs);
          end
        end
        2, 3, 4: begin
          cin[0] = 8'($urandom_range(254, 252));
          for (i = 1; i < 5; i++) begin
            if ($urandom_range(4) != 0) begin
              cin[i] = shift_digit($urandom_range(214), ofs);
            end
          end
        end
        5, 6: cin[0] = 8'($urandom_range(248));
        7: cin[0] = 8'($urandom_range(ofs));
        default: ;
      endcase
    end
    return make_item(mode, v, cin[0], cin[1], cin[2], cin[3], cin[4]);
  endfunction

  task automatic log_mismatch(input string what, input out_item_t want, input out_item_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected bytes %h %h %h %h %h len %0d value %0d status %0d",
               $realtime, what, want.code_out0, want.code_out1, want.code_out2,
               want.code_out3, want.code_out4, want.code_length, want.value_out,
               want.status);
      $display("    got bytes %h %h %h %h %h len %0d value %0d status %0d",
               got.code_out0, got.code_out1, got.code_out2, got.code_out3,
               got.code_out4, got.code_length, got.value_out, got.status);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (queued_requests.size() != 0 || start || predicted_outputs.size() != 0);
  endtask

  // Driver: a new item goes out once the held one has been taken, unless the sender idles.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      item_taken = 1'b0;
      if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= queued_requests.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (predicted_outputs.size() == 0) begin
          log_mismatch("result with no item pending", '0, out_item);
        end else if (out_item !== predicted_outputs[0]) begin
          log_mismatch("result mismatch", predicted_outputs.pop_front(), out_item);
        end else begin
          void'(predicted_outputs.pop_front());
        end
      end
      if (start && !busy) begin
        predicted_outputs.push_back(codec_predict(in_item, digit_ofs));
        item_taken = 1'b1;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (12) @(negedge clk);
        digit_ofs = (ph == 5) ? 6'($urandom_range(34)) : phase_ofs[ph];
        cfg_data <= digit_ofs;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      @(posedge clk);
      idle_pct = phase_idle[ph];
      if (ph == 0) begin
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd0, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd214, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd215, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd859, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd860, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd46225, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, CODE_CEIL - 32'd1, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, CODE_CEIL, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'h8000_0000, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, NEG_MARK, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, PFX_ONE_A, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd251, 8'd255, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, PFX_MULTI, 8'd1, 8'd2, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd254, 8'd255, 8'd255,
                                            8'd255, 8'd255));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd254, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd1, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd248, 0, 0, 0, 0));
      end else if (ph == 1) begin
        // With no offset, zero digits become zero bytes that still count toward the length.
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd0, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_ENCODE, 32'd46225, 0, 0, 0, 0, 0));
        queued_requests.push_back(make_item(MODE_DECODE, 32'd0, 8'd0, 0, 0, 0, 0));
      end
      repeat (phase_items[ph]) queued_requests.push_back(random_item(digit_ofs));
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
